// File: hw/rtl/mrovq_pkg.sv
// Shared types and constants for the multi-rail overvoltage qualifier.
package mrovq_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int RAIL_BITS    = 3;
  localparam int THRESH_BITS  = 10;
  localparam int COUNT_BITS   = 8;
  localparam int THRESH_REGS  = 5;
  localparam int CFG_BITS     = 10;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_NEG5  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_POS5  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_NEG12 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_POS12 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_POS24 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_LIMIT  = 3'd5;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd10;
  localparam logic [COUNT_BITS-1:0]  LIMIT_RESET  = 8'd10;

  typedef struct packed {
    logic [RAIL_BITS-1:0]   rail;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic rail_warning;
    logic low_rails_cutoff;
    logic rail24_cutoff;
  } out_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] over_count;
    logic [COUNT_BITS-1:0] under_count;
  } counts_t;

endpackage

// File: hw/rtl/multi_rail_overvoltage_qualifier.sv
// Top level: per-rail debounced overvoltage qualifier with counters held in a RAM.
// Usage: one sample request per cycle is sustained unless out_ready holds the output. The
// accepting edge registers the read of the rail's over/under counter pair from the counter
// RAM; the update stage then updates it, and as it advances writes it back and loads the
// result register.
// A write to the same rail in the cycle of the read is forwarded, so back-to-back
// samples on one rail need no bubble. Counter entries have valid bits that reset
// clears, so the block takes requests right after reset. Rails at or above
// RAIL_COUNT change nothing and report a zero rail warning.
module multi_rail_overvoltage_qualifier #(
  parameter int RAIL_COUNT = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mrovq_pkg::in_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mrovq_pkg::out_t                        out_data,
  input  logic                                   cfg_we,
  input  logic [mrovq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mrovq_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int AW = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
  localparam int CW = 2 * mrovq_pkg::COUNT_BITS;

  logic [mrovq_pkg::THRESH_BITS-1:0] thresholds [mrovq_pkg::THRESH_REGS];
  logic [mrovq_pkg::COUNT_BITS-1:0]  count_limit;
  logic [RAIL_COUNT-1:0]             warn;
  logic [(1 << AW)-1:0]              entry_ok;

  logic                              s1_valid;
  mrovq_pkg::in_t                    s1_req;
  logic                              s1_fwd_hit;
  mrovq_pkg::counts_t                s1_fwd_data;
  logic                              s1_entry_ok;

  logic                              s1_advance;
  logic                              s1_hold;
  logic                              s1_in_range;
  logic [AW-1:0]                     rd_addr;
  logic [CW-1:0]                     ram_q;
  mrovq_pkg::counts_t                cur;
  mrovq_pkg::counts_t                upd;
  logic [2:0]                        ti;
  logic                              is_over;
  logic [mrovq_pkg::COUNT_BITS-1:0]  inc;
  logic [mrovq_pkg::COUNT_BITS-1:0]  clamp;
  logic                              own_next;
  logic                              warn_set;
  logic                              warn_clr;
  logic [RAIL_COUNT-1:0]             warn_next;
  logic                              low_next;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  mrovq_pkg::out_t                   res;

  assign s1_advance  = s1_valid && (!out_valid || out_ready);
  assign s1_hold     = s1_valid && !s1_advance;
  assign in_ready    = !s1_valid || s1_advance;
  assign rd_addr     = s1_hold ? s1_req.rail[AW-1:0] : in_data.rail[AW-1:0];
  assign s1_in_range = 32'(s1_req.rail) < RAIL_COUNT;
  assign wr_en       = s1_advance && s1_in_range;
  assign wr_addr     = s1_req.rail[AW-1:0];

  mrovq_ram #(
    .WIDTH (CW),
    .DEPTH (RAIL_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (upd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    if (s1_fwd_hit) begin
      cur = s1_fwd_data;
    end else if (s1_entry_ok) begin
      cur = mrovq_pkg::counts_t'(ram_q);
    end else begin
      cur = '0;
    end

    if (32'(s1_req.rail) < mrovq_pkg::THRESH_REGS) begin
      ti = s1_req.rail;
    end else begin
      ti = 3'(mrovq_pkg::THRESH_REGS - 1);
    end
    is_over = s1_req.sample > thresholds[ti];
    clamp   = count_limit + 8'd1;
    upd     = cur;
    warn_set = 1'b0;
    warn_clr = 1'b0;

    if (is_over) begin
      inc = (cur.over_count == '1) ? cur.over_count : cur.over_count + 8'd1;
      upd.over_count = inc;
      if (inc > count_limit) begin
        upd.over_count  = clamp;
        upd.under_count = '0;
        warn_set        = 1'b1;
      end
    end else begin
      inc = (cur.under_count == '1) ? cur.under_count : cur.under_count + 8'd1;
      upd.under_count = inc;
      if (inc > count_limit) begin
        upd.under_count = clamp;
        upd.over_count  = '0;
        warn_clr        = 1'b1;
      end
    end

    warn_next = warn;
    own_next  = 1'b0;
    for (int i = 0; i < RAIL_COUNT; i++) begin
      if (s1_in_range && (wr_addr == AW'(i))) begin
        if (warn_set) begin
          warn_next[i] = 1'b1;
        end else if (warn_clr) begin
          warn_next[i] = 1'b0;
        end
        own_next = warn_next[i];
      end
    end

    low_next = 1'b0;
    for (int i = 0; i < RAIL_COUNT - 1; i++) begin
      low_next = low_next | warn_next[i];
    end

    res.rail_warning     = own_next;
    res.low_rails_cutoff = low_next;
    res.rail24_cutoff    = warn_next[RAIL_COUNT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mrovq_pkg::THRESH_REGS; i++) begin
        thresholds[i] <= mrovq_pkg::THRESH_RESET;
      end
      count_limit <= mrovq_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrovq_pkg::REG_THRESH_NEG5:  thresholds[0] <= cfg_data;
        mrovq_pkg::REG_THRESH_POS5:  thresholds[1] <= cfg_data;
        mrovq_pkg::REG_THRESH_NEG12: thresholds[2] <= cfg_data;
        mrovq_pkg::REG_THRESH_POS12: thresholds[3] <= cfg_data;
        mrovq_pkg::REG_THRESH_POS24: thresholds[4] <= cfg_data;
        mrovq_pkg::REG_COUNT_LIMIT:  count_limit <= cfg_data[mrovq_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      warn      <= '0;
      entry_ok  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        warn      <= warn_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        entry_ok[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_req <= in_data;
    end
    s1_fwd_hit  <= wr_en && (wr_addr == rd_addr);
    s1_fwd_data <= upd;
    s1_entry_ok <= entry_ok[rd_addr];
    if (s1_advance) begin
      out_data <= res;
    end
  end

  // forwarded data always belongs to the rail now in the update stage
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd_hit |-> s1_req.rail[AW-1:0] == $past(wr_addr))
    else $error("forward hit on wrong rail");

  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> 32'(s1_req.rail) < RAIL_COUNT)
    else $error("counter write for out-of-range rail");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rail24_cutoff == warn[RAIL_COUNT-1])
    else $error("24V cutoff out of step with warnings");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.low_rails_cutoff |-> (warn & ~(RAIL_COUNT'(1) << (RAIL_COUNT - 1))) == '0)
    else $error("low rails cutoff out of step with warnings");

endmodule

// File: hw/rtl/mrovq_ram.sv
// Generic simple dual-port RAM with registered read data.
module mrovq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/tb_multi_rail_overvoltage_qualifier.sv
// Testbench for the multi-rail overvoltage qualifier: directed and random traffic.
`timescale 1ns / 1ps

module tb_multi_rail_overvoltage_qualifier;

  typedef logic [mrovq_pkg::RAIL_BITS-1:0]    rail_t;
  typedef logic [mrovq_pkg::SAMPLE_BITS-1:0]  level_t;
  typedef logic [mrovq_pkg::THRESH_BITS-1:0]  thr_t;
  typedef logic [mrovq_pkg::COUNT_BITS-1:0]   cnt_t;
  typedef logic [mrovq_pkg::CFG_IDX_BITS-1:0] idx_t;
  typedef logic [mrovq_pkg::CFG_BITS-1:0]     cfg_t;
  typedef logic [mrovq_pkg::THRESH_REGS-1:0][mrovq_pkg::THRESH_BITS-1:0] levels_t;

  localparam int RAIL_CNT = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam idx_t REG_UNUSED_LO = 3'd6;
  localparam idx_t REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    mrovq_pkg::in_t  req;
    mrovq_pkg::out_t flags;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mrovq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mrovq_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  idx_t cfg_index = '0;
  cfg_t cfg_data = '0;

  levels_t thresh_q = {mrovq_pkg::THRESH_REGS{mrovq_pkg::THRESH_RESET}};
  cnt_t limit_q = mrovq_pkg::LIMIT_RESET;
  cnt_t over_cnt [RAIL_CNT] = '{default: '0};
  cnt_t under_cnt [RAIL_CNT] = '{default: '0};
  logic [RAIL_CNT-1:0] warn_q = '0;

  pending_t pending_flags [$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off_cycles = 0;
  bit idle_en = 1'b1;

  multi_rail_overvoltage_qualifier #(
    .RAIL_COUNT(RAIL_CNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic mrovq_pkg::out_t qualify_sample(mrovq_pkg::in_t req);
    mrovq_pkg::out_t flags;
    int r;
    int ti;
    flags = '0;
    r = int'(req.rail);
    if (r < RAIL_CNT) begin
      ti = (r < mrovq_pkg::THRESH_REGS) ? r : mrovq_pkg::THRESH_REGS - 1;
      if (req.sample > thresh_q[ti]) begin
        if (over_cnt[r] != '1) over_cnt[r] = over_cnt[r] + 8'd1;
        if (over_cnt[r] > limit_q) begin
          over_cnt[r] = limit_q + 8'd1;
          under_cnt[r] = '0;
          warn_q[r] = 1'b1;
        end
      end else begin
        if (under_cnt[r] != '1) under_cnt[r] = under_cnt[r] + 8'd1;
        if (under_cnt[r] > limit_q) begin
          under_cnt[r] = limit_q + 8'd1;
          over_cnt[r] = '0;
          warn_q[r] = 1'b0;
        end
      end
      flags.rail_warning = warn_q[r];
    end
    flags.low_rails_cutoff = |warn_q[RAIL_CNT-2:0];
    flags.rail24_cutoff = warn_q[RAIL_CNT-1];
    return flags;
  endfunction

  function automatic level_t pick_level(input thr_t thr, input bit over);
    if (over && thr != '1) begin
      if ($urandom_range(3) == 0) return level_t'(thr + 1);
      return level_t'($urandom_range(1023, thr + 1));
    end
    if (!over) begin
      if ($urandom_range(3) == 0) return level_t'(thr);
      return level_t'($urandom_range(thr, 0));
    end
    return level_t'($urandom_range(1023));
  endfunction

  task automatic log_mismatch(input string what, input pending_t item,
                              input mrovq_pkg::out_t seen);
    errors++;
    if (errors <= 10)
      $display("%s: rail %0d sample %0d expected %b got %b", what, item.req.rail,
               item.req.sample, item.flags, seen);
  endtask

  task automatic send_request(input rail_t rail, input level_t level);
    pending_t item;
    while (idle_en && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.req.rail = rail;
    item.req.sample = level;
    in_valid <= 1'b1;
    in_data <= item.req;
    do @(posedge clk); while (!in_ready);
    item.flags = qualify_sample(item.req);
    pending_flags.push_back(item);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input idx_t idx, input cfg_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx <= mrovq_pkg::REG_THRESH_POS24) thresh_q[idx] = value;
    else if (idx == mrovq_pkg::REG_COUNT_LIMIT) limit_q = value[mrovq_pkg::COUNT_BITS-1:0];
  endtask

  task automatic apply_settings(input levels_t levels, input cnt_t limit);
    settle_idle();
    for (int i = 0; i < mrovq_pkg::THRESH_REGS; i++)
      write_reg(idx_t'(int'(mrovq_pkg::REG_THRESH_NEG5) + i), levels[i]);
    write_reg(mrovq_pkg::REG_COUNT_LIMIT, cfg_t'(limit));
    cfg_we <= 1'b0;
  endtask

  // mostly same-rail runs that can push the counters past the limit, some noise
  task automatic run_traffic(input int n);
    int sent;
    int len;
    bit over;
    rail_t r;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        r = rail_t'($urandom_range(RAIL_CNT - 1));
        over = ($urandom_range(1) == 1);
        len = $urandom_range(int'(limit_q) + 3, 1);
        if (len > 40) len = 40;
        repeat (len) begin
          send_request(r, pick_level(thresh_q[r], ($urandom_range(9) == 0) ? !over : over));
          sent++;
        end
      end else begin
        send_request(rail_t'($urandom_range(7)), level_t'($urandom_range(1023)));
        sent++;
      end
    end
  endtask

  task automatic test_reset_levels();
    send_request(3'd0, 10'd0);
    send_request(3'd1, 10'd1023);
    send_request(3'd2, 10'd10);
    send_request(3'd3, 10'd11);
    send_request(3'd4, 10'd1023);
    send_request(3'd5, 10'd1023);
    send_request(3'd6, 10'd0);
    send_request(3'd7, 10'd1023);
  endtask

  task automatic test_zero_limit();
    levels_t levels;
    levels = {10'd0, 10'd10, 10'd512, 10'd1023, 10'd0};
    apply_settings(levels, 8'd0);
    send_request(3'd0, 10'd0);
    send_request(3'd0, 10'd1);
    send_request(3'd1, 10'd1023);
    send_request(3'd4, 10'd1);
    send_request(3'd7, 10'd0);
    send_request(3'd3, 10'd11);
    send_request(3'd0, 10'd0);
    send_request(3'd3, 10'd10);
  endtask

  task automatic test_lowered_limit();
    levels_t levels;
    levels = {mrovq_pkg::THRESH_REGS{10'd100}};
    apply_settings(levels, 8'd20);
    repeat (5) send_request(3'd2, 10'd600);
    apply_settings(levels, 8'd2);
    send_request(3'd2, 10'd600);
    repeat (3) send_request(3'd2, 10'd0);
  endtask

  task automatic test_unused_index();
    settle_idle();
    write_reg(REG_UNUSED_LO, cfg_t'($urandom_range(1023)));
    write_reg(REG_UNUSED_HI, cfg_t'($urandom_range(1023)));
    cfg_we <= 1'b0;
    run_traffic(30);
  endtask

  task automatic test_count_saturation();
    levels_t levels;
    for (int i = 0; i < mrovq_pkg::THRESH_REGS; i++) levels[i] = thr_t'($urandom_range(800));
    apply_settings(levels, 8'd254);
    repeat (260) send_request(3'd4, pick_level(thresh_q[4], 1'b1));
    run_traffic(40);
  endtask

  task automatic test_random_settings();
    levels_t levels;
    cnt_t limit;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        levels = '0;
        limit = 8'd0;
      end else if (phase == 1) begin
        levels = '1;
        limit = 8'd254;
      end else begin
        for (int i = 0; i < mrovq_pkg::THRESH_REGS; i++)
          levels[i] = thr_t'($urandom_range(1023));
        limit = cnt_t'($urandom_range(8));
      end
      apply_settings(levels, limit);
      run_traffic(60);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 150;
    run_traffic(40);
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    run_traffic(150);
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else out_ready <= !(idle_en && $urandom_range(99) < 34);
  end

  always @(posedge clk) begin
    pending_t item;
    if (!rst && out_valid && out_ready) begin
      if (pending_flags.size() == 0) begin
        log_mismatch("unexpected result", '0, out_data);
      end else begin
        item = pending_flags.pop_front();
        if (out_data.rail_warning !== item.flags.rail_warning ||
            out_data.low_rails_cutoff !== item.flags.low_rails_cutoff ||
            out_data.rail24_cutoff !== item.flags.rail24_cutoff)
          log_mismatch("mismatch", item, out_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("multi_rail_overvoltage_qualifier test failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_levels();
    test_zero_limit();
    test_lowered_limit();
    test_unused_index();
    test_count_saturation();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    settle_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("multi_rail_overvoltage_qualifier test passed");
    else $display("multi_rail_overvoltage_qualifier test failed");
    $finish;
  end

endmodule
